FILE: hw/rtl/rms_emittance_twiss_unit_macros.svh
// ----------------------------------------------------------------------------
// rms_emittance_twiss_unit_macros.svh
// Assertion macros used by the checker of the emittance unit.
// ----------------------------------------------------------------------------
`ifndef RMS_EMITTANCE_TWISS_UNIT_MACROS_SVH
`define RMS_EMITTANCE_TWISS_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RMSET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define RMSET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rmset_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmset_pkg
// Constants, codes and control structs of the RMS emittance / Twiss unit.
// ----------------------------------------------------------------------------
package rmset_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CNT_W         = 21;
  localparam int MAX_PARTICLES = 1048576;
  localparam int CNT_MAX       = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CNT_LIMIT =
    CNT_W'((MAX_PARTICLES < CNT_MAX) ? MAX_PARTICLES : CNT_MAX);
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 64;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CHECK,
    ST_SLX_GO, ST_SLX_WT, ST_SLY_GO, ST_SLY_WT,
    ST_PMUL, ST_PDRAIN, ST_LOR_GO, ST_LOR_WT, ST_LASTCHK,
    ST_PLANE, ST_WMUL, ST_WDRAIN, ST_WCHK,
    ST_EM_SQ_GO, ST_EM_SQ_WT, ST_EM_DV_GO, ST_EM_DV_WT, ST_ECHK,
    ST_DEN, ST_DEN_WT,
    ST_BETA_GO, ST_BETA_WT, ST_GAMMA_GO, ST_GAMMA_WT, ST_ALPHA_GO, ST_ALPHA_WT,
    ST_ZERO, ST_NEXT, ST_MEAN_GO, ST_MEAN_WT, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    MO_PXX, MO_PYY, MO_PZZ,
    MO_XX, MO_XSXS, MO_XXS,
    MO_YY, MO_YSYS, MO_YYS,
    MO_A00, MO_A01, MO_A10, MO_A11,
    MO_B00, MO_B01, MO_B10, MO_B11,
    MO_DEN
  } mul_op_t;

  typedef enum logic [2:0] {
    DV_SLX, DV_SLY, DV_EMIT, DV_BETA, DV_GAMMA, DV_ALPHA, DV_MEAN
  } div_op_t;

  typedef enum logic {
    SQ_LOR, SQ_EMIT
  } sqrt_op_t;

  typedef struct packed {
    logic     load;
    logic     flag_bad;
    logic     mul_go;
    mul_op_t  mul_op;
    logic     div_go;
    div_op_t  div_op;
    logic     sqrt_go;
    sqrt_op_t sqrt_op;
    logic     plane;
    logic     clr_wide;
    logic     plane_zero;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic pz_bad;
    logic cnt_full;
    logic cnt_zero;
    logic last;
    logic div_done;
    logic sqrt_done;
    logic wide_neg;
    logic emit_zero;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic        [31:0]      emit_x;
    logic        [31:0]      beta_x;
    logic signed [31:0]      alpha_x;
    logic        [31:0]      twiss_gamma_x;
    logic        [31:0]      emit_y;
    logic        [31:0]      beta_y;
    logic signed [31:0]      alpha_y;
    logic        [31:0]      twiss_gamma_y;
    logic        [31:0]      mean_lorentz;
    logic        [CNT_W-1:0] particle_count;
    logic        [1:0]       status;
  } result_t;

endpackage

FILE: hw/rtl/rmset_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmset_if
// Valid/ready channels of the emittance unit: particle in, result out.
// ----------------------------------------------------------------------------
interface rmset_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] mom_x;
  logic signed [31:0] mom_y;
  logic signed [31:0] mom_z;
  logic               last;

  modport source (output valid, pos_x, pos_y, mom_x, mom_y, mom_z, last, input ready);
  modport sink   (input valid, pos_x, pos_y, mom_x, mom_y, mom_z, last, output ready);
endinterface

interface rmset_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] emit_x;
  logic        [31:0] beta_x;
  logic signed [31:0] alpha_x;
  logic        [31:0] twiss_gamma_x;
  logic        [31:0] emit_y;
  logic        [31:0] beta_y;
  logic signed [31:0] alpha_y;
  logic        [31:0] twiss_gamma_y;
  logic        [31:0] mean_lorentz;
  logic        [20:0] particle_count;
  logic        [1:0]  status;

  modport source (output valid, emit_x, beta_x, alpha_x, twiss_gamma_x, emit_y, beta_y,
                  alpha_y, twiss_gamma_y, mean_lorentz, particle_count, status,
                  input ready);
  modport sink   (input valid, emit_x, beta_x, alpha_x, twiss_gamma_x, emit_y, beta_y,
                  alpha_y, twiss_gamma_y, mean_lorentz, particle_count, status,
                  output ready);
endinterface

FILE: hw/rtl/rmset_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmset_div
// Unsigned 64 by 64 bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmset_div
  import rmset_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dvs_r;
  logic [6:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] shifted;
  logic [64:0] diff;
  logic        fits;

  // Shift in the next dividend bit and trial subtract
  always_comb begin
    shifted = {rem_r, quo_r[63]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[63:0] : shifted[63:0];
    quo_nxt = {quo_r[62:0], fits};
  end

  // Control: count steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 7'(DIV_STEPS);
      end else if (busy_r) begin
        step_r <= step_r - 7'd1;
        if (step_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/rmset_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmset_sqrt
// Floor square root of a 128 bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmset_sqrt
  import rmset_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] radicand,
  output logic         done,
  output logic [63:0]  root
);

  logic [127:0] rad_r;
  logic [65:0]  rem_r, rem_nxt;
  logic [63:0]  root_r, root_nxt;
  logic [6:0]   step_r;
  logic         busy_r;
  logic         done_r;
  logic [67:0]  r4;
  logic [67:0]  trial;
  logic [67:0]  diff;
  logic         fits;

  // Bring down two radicand bits and try root*4+1
  always_comb begin
    r4       = {rem_r, rad_r[127:126]};
    trial    = {2'b00, root_r, 2'b01};
    diff     = r4 - trial;
    fits     = (r4 >= trial);
    rem_nxt  = fits ? diff[65:0] : r4[65:0];
    root_nxt = {root_r[62:0], fits};
  end

  // Control: count steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 7'(SQRT_STEPS);
      end else if (busy_r) begin
        step_r <= step_r - 7'd1;
        if (step_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: radicand shifter, remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[125:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hw/rtl/rmset_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmset_dpath
// Datapath: particle registers, moment sums, shared multiplier, divider and
// square root unit, per plane results and the output register.
// ----------------------------------------------------------------------------
module rmset_dpath
  import rmset_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_mom_x,
  input  logic signed [31:0] in_mom_y,
  input  logic signed [31:0] in_mom_z,
  input  logic               in_last,
  input  logic               out_ready,
  output logic               out_valid,
  output result_t            res
);

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] usat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s    = {1'b0, a} + {1'b0, b};
    usat = s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] ssat(input logic [63:0] a, input logic neg,
                                       input logic [63:0] m);
    logic [64:0] t;
    logic [64:0] s;
    t = neg ? (65'd0 - {1'b0, m}) : {1'b0, m};
    s = {a[63], a} + t;
    if (s[64] != s[63]) begin
      ssat = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      ssat = s[63:0];
    end
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] q);
    sat32 = (|q[63:32]) ? '1 : q[31:0];
  endfunction

  // Magnitude with sign, clipped to the signed 32 bit range
  function automatic logic [31:0] sat_signed(input logic [63:0] m, input logic neg);
    if (neg) begin
      sat_signed = (m > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end else begin
      sat_signed = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
  endfunction

  logic signed [31:0] x_r, y_r, px_r, py_r, pz_r;
  logic               last_r;
  logic [63:0]        sxx_r, sxs_r, syy_r, sys_r, slor_r;
  logic [63:0]        sxp_r, syp_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               bad_r;
  logic               zero_r;
  logic [31:0]        xs_r, ys_r;
  logic [63:0]        lsum_r;
  logic [128:0]       acc_r;
  logic [63:0]        root_r;
  logic [63:0]        den_r;
  logic [31:0]        emit_r  [2];
  logic [31:0]        beta_r  [2];
  logic [31:0]        alpha_r [2];
  logic [31:0]        gamma_r [2];
  logic [31:0]        mean_r;
  logic [63:0]        prod_r;
  logic               prod_neg_r;
  logic               prod_vld_r;
  mul_op_t            prod_op_r;
  div_op_t            div_op_r;
  sqrt_op_t           sqrt_op_r;
  logic               plane_r;
  result_t            res_r;
  logic               out_valid_r;

  logic [63:0]  sqq, spp, sqp, sqp_mag;
  logic         sqp_pos;
  logic [31:0]  mul_a, mul_b;
  logic         mul_neg;
  logic [63:0]  mul_p;
  logic [128:0] wterm;
  logic         wsub;
  logic [63:0]  dvd, dvs;
  logic         div_done;
  logic [63:0]  div_q;
  logic [127:0] rad;
  logic         sqrt_done;
  logic [63:0]  sqrt_q;

  // Select the plane being reduced
  always_comb begin
    sqq     = plane_r ? syy_r : sxx_r;
    spp     = plane_r ? sys_r : sxs_r;
    sqp     = plane_r ? syp_r : sxp_r;
    sqp_mag = mag64(sqp);
    sqp_pos = !sqp[63] && (sqp != 64'd0);
  end

  // Multiplier operand selection
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (cmd.mul_op)
      MO_PXX:  begin mul_a = mag32(px_r); mul_b = mag32(px_r); end
      MO_PYY:  begin mul_a = mag32(py_r); mul_b = mag32(py_r); end
      MO_PZZ:  begin mul_a = mag32(pz_r); mul_b = mag32(pz_r); end
      MO_XX:   begin mul_a = mag32(x_r);  mul_b = mag32(x_r);  end
      MO_XSXS: begin mul_a = mag32(xs_r); mul_b = mag32(xs_r); end
      MO_XXS: begin
        mul_a   = mag32(x_r);
        mul_b   = mag32(xs_r);
        mul_neg = x_r[31] ^ xs_r[31];
      end
      MO_YY:   begin mul_a = mag32(y_r);  mul_b = mag32(y_r);  end
      MO_YSYS: begin mul_a = mag32(ys_r); mul_b = mag32(ys_r); end
      MO_YYS: begin
        mul_a   = mag32(y_r);
        mul_b   = mag32(ys_r);
        mul_neg = y_r[31] ^ ys_r[31];
      end
      MO_A00:  begin mul_a = sqq[31:0];      mul_b = spp[31:0];      end
      MO_A01:  begin mul_a = sqq[31:0];      mul_b = spp[63:32];     end
      MO_A10:  begin mul_a = sqq[63:32];     mul_b = spp[31:0];      end
      MO_A11:  begin mul_a = sqq[63:32];     mul_b = spp[63:32];     end
      MO_B00:  begin mul_a = sqp_mag[31:0];  mul_b = sqp_mag[31:0];  end
      MO_B01:  begin mul_a = sqp_mag[31:0];  mul_b = sqp_mag[63:32]; end
      MO_B10:  begin mul_a = sqp_mag[63:32]; mul_b = sqp_mag[31:0];  end
      MO_B11:  begin mul_a = sqp_mag[63:32]; mul_b = sqp_mag[63:32]; end
      MO_DEN:  begin mul_a = {{(32-CNT_W){1'b0}}, cnt_r}; mul_b = emit_r[plane_r]; end
      default: ;
    endcase
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // Place a registered partial product into the 128 bit determinant
  always_comb begin
    wterm = '0;
    unique case (prod_op_r)
      MO_A00, MO_B00: wterm = {65'd0, prod_r};
      MO_A01, MO_A10, MO_B01, MO_B10: wterm = {33'd0, prod_r, 32'd0};
      MO_A11, MO_B11: wterm = {1'b0, prod_r, 64'd0};
      default: wterm = '0;
    endcase
    wsub = (prod_op_r == MO_B00) || (prod_op_r == MO_B01) ||
           (prod_op_r == MO_B10) || (prod_op_r == MO_B11);
  end

  // Divider operand selection
  always_comb begin
    dvd = '0;
    dvs = 64'd1;
    unique case (cmd.div_op)
      DV_SLX:   begin dvd = {32'd0, mag32(px_r)} << FRAC_BITS; dvs = {32'd0, pz_r}; end
      DV_SLY:   begin dvd = {32'd0, mag32(py_r)} << FRAC_BITS; dvs = {32'd0, pz_r}; end
      DV_EMIT:  begin dvd = root_r; dvs = {{(64-CNT_W){1'b0}}, cnt_r} << FRAC_BITS; end
      DV_BETA:  begin dvd = sqq;     dvs = den_r; end
      DV_GAMMA: begin dvd = spp;     dvs = den_r; end
      DV_ALPHA: begin dvd = sqp_mag; dvs = den_r; end
      DV_MEAN:  begin dvd = slor_r;  dvs = {{(64-CNT_W){1'b0}}, cnt_r}; end
      default: ;
    endcase
    rad = (cmd.sqrt_op == SQ_LOR) ? {64'd0, lsum_r} : acc_r[127:0];
  end

  rmset_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  rmset_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_go),
    .radicand (rad),
    .done     (sqrt_done),
    .root     (sqrt_q)
  );

  // Latch the accepted particle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      px_r   <= in_mom_x;
      py_r   <= in_mom_y;
      pz_r   <= in_mom_z;
      last_r <= in_last;
    end
  end

  // Register the product and the unit operations in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    plane_r <= cmd.plane;
    if (cmd.mul_go) begin
      prod_r     <= mul_p;
      prod_neg_r <= mul_neg;
      prod_op_r  <= cmd.mul_op;
    end
    if (cmd.div_go) begin
      div_op_r <= cmd.div_op;
    end
    if (cmd.sqrt_go) begin
      sqrt_op_r <= cmd.sqrt_op;
    end
  end

  // Moment sums, count and flags
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      sxx_r  <= '0;
      sxs_r  <= '0;
      sxp_r  <= '0;
      syy_r  <= '0;
      sys_r  <= '0;
      syp_r  <= '0;
      slor_r <= '0;
      cnt_r  <= '0;
      bad_r  <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      if (cmd.flag_bad) begin
        bad_r <= 1'b1;
      end
      if (prod_vld_r) begin
        unique case (prod_op_r)
          MO_XX:   sxx_r <= usat(sxx_r, prod_r);
          MO_XSXS: sxs_r <= usat(sxs_r, prod_r);
          MO_XXS:  sxp_r <= ssat(sxp_r, prod_neg_r, prod_r);
          MO_YY:   syy_r <= usat(syy_r, prod_r);
          MO_YSYS: sys_r <= usat(sys_r, prod_r);
          MO_YYS:  syp_r <= ssat(syp_r, prod_neg_r, prod_r);
          default: ;
        endcase
      end
      if (sqrt_done && (sqrt_op_r == SQ_LOR)) begin
        slor_r <= usat(slor_r, sqrt_q);
        cnt_r  <= cnt_r + 1'b1;
      end
      if (cmd.plane_zero) begin
        zero_r <= 1'b1;
      end
    end
  end

  // Working values: Lorentz sum, determinant, root, denominator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lsum_r <= 64'd1 << (2 * FRAC_BITS);
    end else if (prod_vld_r && ((prod_op_r == MO_PXX) || (prod_op_r == MO_PYY) ||
                                (prod_op_r == MO_PZZ))) begin
      lsum_r <= lsum_r + prod_r;
    end
    if (cmd.clr_wide) begin
      acc_r <= '0;
    end else if (prod_vld_r && (wterm != '0)) begin
      acc_r <= wsub ? (acc_r - wterm) : (acc_r + wterm);
    end
    if (prod_vld_r && (prod_op_r == MO_DEN)) begin
      den_r <= prod_r;
    end
    if (sqrt_done && (sqrt_op_r == SQ_EMIT)) begin
      root_r <= sqrt_q;
    end
  end

  // Quotients to their destinations
  always_ff @(posedge clk) begin
    if (cmd.plane_zero) begin
      emit_r[plane_r]  <= '0;
      beta_r[plane_r]  <= '1;
      gamma_r[plane_r] <= '1;
      alpha_r[plane_r] <= sat_signed((sqp == 64'd0) ? 64'd0 : 64'h8000_0000, sqp_pos);
    end else if (div_done) begin
      unique case (div_op_r)
        DV_SLX:   xs_r <= sat_signed(div_q, px_r[31]);
        DV_SLY:   ys_r <= sat_signed(div_q, py_r[31]);
        DV_EMIT:  emit_r[plane_r]  <= sat32(div_q);
        DV_BETA:  beta_r[plane_r]  <= sat32(div_q);
        DV_GAMMA: gamma_r[plane_r] <= sat32(div_q);
        DV_ALPHA: alpha_r[plane_r] <= sat_signed(div_q, sqp_pos);
        DV_MEAN:  mean_r <= sat32(div_q);
        default: ;
      endcase
    end
  end

  // Output register: load the result, hold it until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r.emit_x         <= emit_r[0];
      res_r.beta_x         <= beta_r[0];
      res_r.alpha_x        <= alpha_r[0];
      res_r.twiss_gamma_x  <= gamma_r[0];
      res_r.emit_y         <= emit_r[1];
      res_r.beta_y         <= beta_r[1];
      res_r.alpha_y        <= alpha_r[1];
      res_r.twiss_gamma_y  <= gamma_r[1];
      res_r.mean_lorentz   <= (cnt_r == '0) ? 32'd0 : mean_r;
      res_r.particle_count <= cnt_r;
      res_r.status         <= {zero_r, bad_r};
    end
  end

  // Status to the controller
  always_comb begin
    sts.pz_bad    = pz_r[31] || (pz_r == 32'sd0);
    sts.cnt_full  = (cnt_r >= CNT_LIMIT);
    sts.cnt_zero  = (cnt_r == '0);
    sts.last      = last_r;
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.wide_neg  = acc_r[128];
    sts.emit_zero = (emit_r[plane_r] == 32'd0);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

FILE: hw/rtl/rmset_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmset_ctrl
// Sequencer: steps the datapath through slopes, products, square roots and
// the per plane reduction on the last item.
// ----------------------------------------------------------------------------
module rmset_ctrl
  import rmset_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t  state_r, state_nxt;
  mul_op_t mop_r, mop_nxt;
  logic    plane_r, plane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mop_r   <= MO_PXX;
      plane_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mop_r   <= mop_nxt;
      plane_r <= plane_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    mop_nxt   = mop_r;
    plane_nxt = plane_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.pz_bad || sts.cnt_full) begin
          state_nxt = ST_LASTCHK;
        end else begin
          state_nxt = ST_SLX_GO;
        end
      end
      ST_SLX_GO:   state_nxt = ST_SLX_WT;
      ST_SLX_WT:   if (sts.div_done) state_nxt = ST_SLY_GO;
      ST_SLY_GO:   state_nxt = ST_SLY_WT;
      ST_SLY_WT: begin
        if (sts.div_done) begin
          state_nxt = ST_PMUL;
          mop_nxt   = MO_PXX;
        end
      end
      ST_PMUL: begin
        if (mop_r == MO_YYS) begin
          state_nxt = ST_PDRAIN;
        end else begin
          mop_nxt = mul_op_t'(5'(mop_r + 5'd1));
        end
      end
      ST_PDRAIN:   state_nxt = ST_LOR_GO;
      ST_LOR_GO:   state_nxt = ST_LOR_WT;
      ST_LOR_WT:   if (sts.sqrt_done) state_nxt = ST_LASTCHK;
      ST_LASTCHK: begin
        if (sts.last) begin
          state_nxt = ST_PLANE;
          plane_nxt = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PLANE: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_ZERO;
        end else begin
          state_nxt = ST_WMUL;
          mop_nxt   = MO_A00;
        end
      end
      ST_WMUL: begin
        if (mop_r == MO_B11) begin
          state_nxt = ST_WDRAIN;
        end else begin
          mop_nxt = mul_op_t'(5'(mop_r + 5'd1));
        end
      end
      ST_WDRAIN:   state_nxt = ST_WCHK;
      ST_WCHK:     state_nxt = sts.wide_neg ? ST_ZERO : ST_EM_SQ_GO;
      ST_EM_SQ_GO: state_nxt = ST_EM_SQ_WT;
      ST_EM_SQ_WT: if (sts.sqrt_done) state_nxt = ST_EM_DV_GO;
      ST_EM_DV_GO: state_nxt = ST_EM_DV_WT;
      ST_EM_DV_WT: if (sts.div_done) state_nxt = ST_ECHK;
      ST_ECHK:     state_nxt = sts.emit_zero ? ST_ZERO : ST_DEN;
      ST_DEN:      state_nxt = ST_DEN_WT;
      ST_DEN_WT:   state_nxt = ST_BETA_GO;
      ST_BETA_GO:  state_nxt = ST_BETA_WT;
      ST_BETA_WT:  if (sts.div_done) state_nxt = ST_GAMMA_GO;
      ST_GAMMA_GO: state_nxt = ST_GAMMA_WT;
      ST_GAMMA_WT: if (sts.div_done) state_nxt = ST_ALPHA_GO;
      ST_ALPHA_GO: state_nxt = ST_ALPHA_WT;
      ST_ALPHA_WT: if (sts.div_done) state_nxt = ST_NEXT;
      ST_ZERO:     state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (!plane_r) begin
          plane_nxt = 1'b1;
          state_nxt = ST_PLANE;
        end else begin
          state_nxt = sts.cnt_zero ? ST_OUT : ST_MEAN_GO;
        end
      end
      ST_MEAN_GO:  state_nxt = ST_MEAN_WT;
      ST_MEAN_WT:  if (sts.div_done) state_nxt = ST_OUT;
      ST_OUT:      if (!sts.out_busy) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: commands for the datapath
  always_comb begin
    cmd       = '0;
    cmd.plane = plane_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK:    cmd.flag_bad = sts.pz_bad;
      ST_SLX_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DV_SLX;
      end
      ST_SLY_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DV_SLY;
      end
      ST_PMUL, ST_WMUL: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = mop_r;
      end
      ST_LOR_GO: begin
        cmd.sqrt_go = 1'b1;
        cmd.sqrt_op = SQ_LOR;
      end
      ST_PLANE:    cmd.clr_wide = 1'b1;
      ST_EM_SQ_GO: begin
        cmd.sqrt_go = 1'b1;
        cmd.sqrt_op = SQ_EMIT;
      end
      ST_EM_DV_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DV_EMIT;
      end
      ST_DEN: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = MO_DEN;
      end
      ST_BETA_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DV_BETA;
      end
      ST_GAMMA_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DV_GAMMA;
      end
      ST_ALPHA_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DV_ALPHA;
      end
      ST_ZERO:     cmd.plane_zero = 1'b1;
      ST_MEAN_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DV_MEAN;
      end
      ST_OUT:      cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/rms_emittance_twiss_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_emittance_twiss_unit
// RMS emittance and Twiss parameters of a particle set, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan takes one particle per item (positions, normalized momenta, last).
//   out_chan gives one result item after each item flagged last.
//   Items are taken one at a time; ready is high only while the block waits.
//   A particle with pz <= 0, or one past the count limit, is not summed.
//   A good particle takes two slope divisions and one square root of 64
//   steps each on the shared divider and root unit, plus nine products
//   on the single 32x32 multiplier.
//   A last item adds, per plane, a 128 bit determinant in eight partial
//   products, one 64 step root and four 64 step divisions, then one
//   division for the mean Lorentz factor. A last item that closes an
//   empty set skips the reduction and the mean division.
//   Reset clears all sums, the count, the flags and any pending result.
//   A result waits in the output register while the receiver stalls; the
//   block keeps taking particles and only stalls on the next last item.
// ----------------------------------------------------------------------------
module rms_emittance_twiss_unit
  import rmset_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  rmset_in_if.sink    in_chan,
  rmset_out_if.source out_chan
);

  logic    in_valid;
  logic    in_ready;
  logic    out_valid;
  logic    out_ready;
  cmd_t    cmd;
  sts_t    sts;
  result_t res;

  assign in_valid      = in_chan.valid;
  assign in_chan.ready = in_ready;
  assign out_ready     = out_chan.ready;

  rmset_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rmset_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_pos_x  (in_chan.pos_x),
    .in_pos_y  (in_chan.pos_y),
    .in_mom_x  (in_chan.mom_x),
    .in_mom_y  (in_chan.mom_y),
    .in_mom_z  (in_chan.mom_z),
    .in_last   (in_chan.last),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  // Drive the result channel
  assign out_chan.valid          = out_valid;
  assign out_chan.emit_x         = res.emit_x;
  assign out_chan.beta_x         = res.beta_x;
  assign out_chan.alpha_x        = res.alpha_x;
  assign out_chan.twiss_gamma_x  = res.twiss_gamma_x;
  assign out_chan.emit_y         = res.emit_y;
  assign out_chan.beta_y         = res.beta_y;
  assign out_chan.alpha_y        = res.alpha_y;
  assign out_chan.twiss_gamma_y  = res.twiss_gamma_y;
  assign out_chan.mean_lorentz   = res.mean_lorentz;
  assign out_chan.particle_count = res.particle_count;
  assign out_chan.status         = res.status;

endmodule

FILE: hw/rtl/rmset_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmset_checker
// Checks on the result channel of the emittance unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "rms_emittance_twiss_unit_macros.svh"

module rmset_checker
  import rmset_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_ready,
  input result_t res
);

  // Hold a stalled result item
  `RMSET_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(res), "result changed while stalled")

  // An empty set raises the zero flag and reports a zero mean
  `RMSET_ASSERT_IMP(a_empty, out_valid && (res.particle_count == 21'd0), res.status[1] && (res.mean_lorentz == 32'd0), "empty set not flagged")

  // Zero horizontal emittance saturates beta and gamma
  `RMSET_ASSERT_IMP(a_zero_x, out_valid && (res.emit_x == 32'd0), res.status[1] && (res.beta_x == 32'hFFFF_FFFF) && (res.twiss_gamma_x == 32'hFFFF_FFFF), "zero emittance not saturated")

  // Without the zero flag both emittances are nonzero
  `RMSET_ASSERT_IMP(a_nonzero, out_valid && !res.status[1], (res.emit_x != 32'd0) && (res.emit_y != 32'd0), "zero emittance without flag")

endmodule

bind rms_emittance_twiss_unit rmset_checker u_rmset_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .res       (res)
);
